@@ rtl/core/nlldd_pkg.sv @@
// Package for the nonbinary LLR demapper/depuncture unit.
// Holds field widths, command and register codes and reset values.
// No dependencies; imported by the top level.
package nlldd_pkg;

  // parameter defaults
  localparam int MAX_ORDER_DEF = 64;
  localparam int MAX_BITS_DEF  = 6;

  // payload widths
  localparam int CMD_W     = 2;
  localparam int INDEX_W   = 6;
  localparam int SAMPLE_W  = 16;
  localparam int LLR_W     = 32;
  localparam int SYM_W     = 6;

  // config register widths
  localparam int MODE_W    = 1;
  localparam int BITS_W    = 3;
  localparam int SCALE_W   = 16;

  // APB port
  localparam int APB_AW    = 4;
  localparam int APB_DW    = 32;

  // bit LLR after floor(-4*r*scale/256): |r*scale| < 2^31, >>6 leaves 26 bits
  localparam int BIT_LLR_W = 26;

  // command codes
  localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_RECV  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_PUNCT = 2'd2;

  // register indexes (byte address / 4)
  localparam logic [1:0] REG_MODE  = 2'd0;
  localparam logic [1:0] REG_BITS  = 2'd1;
  localparam logic [1:0] REG_SCALE = 2'd2;

  // demap modes
  localparam logic [MODE_W-1:0] MODE_BPSK    = 1'b0;
  localparam logic [MODE_W-1:0] MODE_MATCHED = 1'b1;

  // reset values
  localparam logic [BITS_W-1:0]  BITS_RST  = 3'd1;
  localparam logic [SCALE_W-1:0] SCALE_RST = 16'd256;

endpackage

@@ rtl/core/nlldd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the constellation point table.
module nlldd_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

@@ rtl/core/nonbinary_llr_demapper_depuncture_unit.sv @@
// Top level of the nonbinary LLR soft demapper with depuncturing.
// Depends on nlldd_pkg and nlldd_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o) takes one word per item: a load
//   word writes one constellation point, a received word carries one sample,
//   a punctured word marks a position that was not sent.
//   Output channel (out_valid_o/out_ready_i) delivers one LLR word per
//   nonzero field element q = 1 .. 2^m-1, rising q, last_o on the top one.
//   APB port holds demap_mode (0x0), bits_per_symbol (0x4), noise_scale (0x8).
// Sequencing (m = effective bits per symbol, n = 2^m-1):
//   load word / unused command: taken in the idle state.
//   BPSK mode: each bit word fills a bit register; the m-th word starts the
//   run, one LLR per cycle unless stalled, as a masked sum of bit registers.
//   matched mode, received word: point 0 is captured, then one shared 38x18
//   multiplier forms the real product, the imaginary product and the scale
//   product of each LLR in turn, so each LLR costs three multiplier passes.
//   matched mode, punctured word: a run of zero LLRs.
// in_ready_o is high only while the sequencer is idle. A finished word sits
// in the output register, so the next input word is taken while it waits.
// If the receiver stalls, the sequencer holds at its output step until the
// output register frees up; nothing is dropped.
// Reset clears the sequencer, the bit registers, the bit position and the
// config registers; the point table is undefined until loaded.
module nonbinary_llr_demapper_depuncture_unit #(
  parameter int MAX_ORDER = nlldd_pkg::MAX_ORDER_DEF,
  parameter int MAX_BITS  = nlldd_pkg::MAX_BITS_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  // input words
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [nlldd_pkg::CMD_W-1:0]           command_i,
  input  logic [nlldd_pkg::INDEX_W-1:0]         point_index_i,
  input  logic signed [nlldd_pkg::SAMPLE_W-1:0] sample_real_i,
  input  logic signed [nlldd_pkg::SAMPLE_W-1:0] sample_imag_i,
  // output words
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic signed [nlldd_pkg::LLR_W-1:0]    llr_value_o,
  output logic [nlldd_pkg::SYM_W-1:0]           symbol_value_o,
  output logic                                  last_o,
  // config port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [nlldd_pkg::APB_AW-1:0]          paddr,
  input  logic [nlldd_pkg::APB_DW-1:0]          pwdata,
  output logic [nlldd_pkg::APB_DW-1:0]          prdata,
  output logic                                  pready
);

  import nlldd_pkg::*;

  localparam int AW       = (MAX_ORDER > 1) ? $clog2(MAX_ORDER) : 1;
  localparam int SW       = (MAX_BITS > 1) ? $clog2(MAX_BITS) : 1;
  localparam int SUM_W    = BIT_LLR_W + 3;
  localparam int MUL_A_W  = 38;
  localparam int MUL_B_W  = 18;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int DIFF_W   = SAMPLE_W + 3;   // 2r - c0 - cq
  localparam int DELTA_W  = SAMPLE_W + 1;   // cq - c0
  localparam int PPROD_W  = DIFF_W + DELTA_W;
  localparam int ACC_W    = PPROD_W + 1;

  // sequencer states
  localparam logic [2:0] ST_IDLE = 3'd0;  // take input words
  localparam logic [2:0] ST_C0   = 3'd1;  // capture point 0
  localparam logic [2:0] ST_MR   = 3'd2;  // real product
  localparam logic [2:0] ST_MI   = 3'd3;  // imag product + accumulate
  localparam logic [2:0] ST_MS   = 3'd4;  // scale product -> output
  localparam logic [2:0] ST_BSUM = 3'd5;  // BPSK masked sums
  localparam logic [2:0] ST_ZOUT = 3'd6;  // zero LLRs for puncture

  // ---------------- config registers ----------------
  logic [MODE_W-1:0]  mode_q;
  logic [BITS_W-1:0]  bits_q;
  logic [SCALE_W-1:0] scale_q;
  logic               cfg_wr;
  logic [1:0]         cfg_idx;

  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_idx = paddr[3:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_BPSK;
      bits_q  <= BITS_RST;
      scale_q <= SCALE_RST;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_MODE:  mode_q  <= pwdata[MODE_W-1:0];
        REG_BITS:  bits_q  <= pwdata[BITS_W-1:0];
        REG_SCALE: scale_q <= pwdata[SCALE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_MODE:  prdata = APB_DW'(mode_q);
      REG_BITS:  prdata = APB_DW'(bits_q);
      REG_SCALE: prdata = APB_DW'(scale_q);
      default:   prdata = '0;
    endcase
  end

  // effective m and top symbol
  logic [2:0]       m_eff;
  logic [SYM_W-1:0] top;

  always_comb begin
    if (bits_q == '0) begin
      m_eff = 3'd1;
    end else if (32'(bits_q) > MAX_BITS) begin
      m_eff = 3'(MAX_BITS);
    end else begin
      m_eff = bits_q;
    end
    top = SYM_W'((7'd1 << m_eff) - 7'd1);
  end

  // ---------------- state ----------------
  logic [2:0]                  state_q, state_d;
  logic [SYM_W-1:0]            q_q, q_d;
  logic [2:0]                  bit_pos_q, bit_pos_d;
  logic signed [BIT_LLR_W-1:0] bit_llr_q [MAX_BITS];
  logic                        bit_we;
  logic [SW-1:0]               bit_waddr;
  logic signed [BIT_LLR_W-1:0] bit_wdata;

  logic signed [SAMPLE_W-1:0]  re_q, im_q, c0r_q, c0i_q;
  logic signed [PPROD_W-1:0]   prod_re_q;
  logic signed [ACC_W-1:0]     acc_q;
  logic                        rd_oor_q;

  logic                        out_valid_q;
  logic signed [LLR_W-1:0]     llr_q, llr_d;
  logic [SYM_W-1:0]            sym_q;
  logic                        last_q;
  logic                        out_load;
  logic                        out_free;

  logic                        in_acc;
  logic                        at_top;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign at_top     = (q_q >= top);

  // ---------------- point table ----------------
  logic                       ram_we;
  logic [AW-1:0]              ram_waddr;
  logic                       ram_re;
  logic [6:0]                 rd_idx;
  logic [2*SAMPLE_W-1:0]      ram_rdata;
  logic signed [SAMPLE_W-1:0] cq_re, cq_im;

  assign ram_we    = in_acc && (command_i == CMD_LOAD)
                     && (32'(point_index_i) < MAX_ORDER);
  assign ram_waddr = point_index_i[AW-1:0];

  nlldd_ram #(
    .WIDTH (2 * SAMPLE_W),
    .DEPTH (MAX_ORDER)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i ({sample_real_i, sample_imag_i}),
    .re_i    (ram_re),
    .raddr_i (rd_idx[AW-1:0]),
    .rdata_o (ram_rdata)
  );

  // entries past the table read as zero
  assign cq_re = rd_oor_q ? '0 : $signed(ram_rdata[2*SAMPLE_W-1:SAMPLE_W]);
  assign cq_im = rd_oor_q ? '0 : $signed(ram_rdata[SAMPLE_W-1:0]);

  // ---------------- shared multiplier ----------------
  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;
  logic signed [DELTA_W-1:0] neg_re;
  logic signed [DIFF_W-1:0]  diff_re, diff_im;
  logic signed [DELTA_W-1:0] dlt_re, dlt_im;
  logic signed [MUL_B_W-1:0] scale_s;

  assign neg_re  = -$signed({sample_real_i[SAMPLE_W-1], sample_real_i});
  assign diff_re = (DIFF_W'(re_q) <<< 1) - DIFF_W'(c0r_q) - DIFF_W'(cq_re);
  assign diff_im = (DIFF_W'(im_q) <<< 1) - DIFF_W'(c0i_q) - DIFF_W'(cq_im);
  assign dlt_re  = DELTA_W'(cq_re) - DELTA_W'(c0r_q);
  assign dlt_im  = DELTA_W'(cq_im) - DELTA_W'(c0i_q);
  assign scale_s = $signed({2'b00, scale_q});

  always_comb begin
    unique case (state_q)
      ST_IDLE: begin
        mul_a = MUL_A_W'(neg_re);
        mul_b = scale_s;
      end
      ST_MR: begin
        mul_a = MUL_A_W'(diff_re);
        mul_b = MUL_B_W'(dlt_re);
      end
      ST_MI: begin
        mul_a = MUL_A_W'(diff_im);
        mul_b = MUL_B_W'(dlt_im);
      end
      ST_MS: begin
        mul_a = MUL_A_W'(acc_q);
        mul_b = scale_s;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  function automatic logic signed [LLR_W-1:0] sat32(input logic signed [35:0] v);
    if (v > 36'sd2147483647) begin
      return 32'sh7FFF_FFFF;
    end else if (v < -36'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[LLR_W-1:0];
    end
  endfunction

  // ---------------- BPSK masked sum ----------------
  logic signed [SUM_W-1:0] bsum;
  logic [2:0]              bidx;

  always_comb begin
    bsum = '0;
    bidx = '0;
    for (int b = 0; b < MAX_BITS; b++) begin
      if (b < 32'(m_eff)) begin
        bidx = 3'(m_eff - 3'(b) - 3'd1);
        if (q_q[bidx]) begin
          bsum = bsum + SUM_W'(bit_llr_q[b]);
        end
      end
    end
  end

  // ---------------- sequencer ----------------
  logic [2:0] pos_sat;
  logic [3:0] pos_inc;

  assign pos_sat = (32'(bit_pos_q) >= MAX_BITS) ? 3'(MAX_BITS - 1) : bit_pos_q;
  assign pos_inc = {1'b0, pos_sat} + 4'd1;

  always_comb begin
    state_d   = state_q;
    q_d       = q_q;
    bit_pos_d = bit_pos_q;
    bit_we    = 1'b0;
    bit_waddr = pos_sat[SW-1:0];
    bit_wdata = (command_i == CMD_RECV) ? $signed(mul_p[31:6]) : '0;
    ram_re    = 1'b0;
    rd_idx    = '0;
    out_load  = 1'b0;
    llr_d     = '0;

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc && (command_i == CMD_RECV || command_i == CMD_PUNCT)) begin
          q_d = SYM_W'(1);
          if (mode_q == MODE_BPSK) begin
            bit_we = 1'b1;
            if (pos_inc < {1'b0, m_eff}) begin
              bit_pos_d = pos_inc[2:0];
            end else begin
              bit_pos_d = '0;
              state_d   = ST_BSUM;
            end
          end else if (command_i == CMD_RECV) begin
            ram_re  = 1'b1;             // fetch point 0
            state_d = ST_C0;
          end else begin
            state_d = ST_ZOUT;
          end
        end
      end
      ST_C0: begin
        ram_re  = 1'b1;
        rd_idx  = {1'b0, q_q};
        state_d = ST_MR;
      end
      ST_MR: begin
        state_d = ST_MI;
      end
      ST_MI: begin
        ram_re  = 1'b1;                 // prefetch next point
        rd_idx  = {1'b0, q_q} + 7'd1;
        state_d = ST_MS;
      end
      ST_MS: begin
        llr_d = sat32($signed(mul_p[PROD_W-1:20]));
        if (out_free) begin
          out_load = 1'b1;
          q_d      = q_q + SYM_W'(1);
          state_d  = at_top ? ST_IDLE : ST_MR;
        end
      end
      ST_BSUM: begin
        llr_d = LLR_W'(bsum);
        if (out_free) begin
          out_load = 1'b1;
          q_d      = q_q + SYM_W'(1);
          state_d  = at_top ? ST_IDLE : ST_BSUM;
        end
      end
      ST_ZOUT: begin
        if (out_free) begin
          out_load = 1'b1;
          q_d      = q_q + SYM_W'(1);
          state_d  = at_top ? ST_IDLE : ST_ZOUT;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      bit_pos_q   <= '0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < MAX_BITS; i++) begin
        bit_llr_q[i] <= '0;
      end
    end else begin
      state_q   <= state_d;
      bit_pos_q <= bit_pos_d;
      if (bit_we) begin
        bit_llr_q[bit_waddr] <= bit_wdata;
      end
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    q_q <= q_d;
    if (in_acc) begin
      re_q <= sample_real_i;
      im_q <= sample_imag_i;
    end
    if (ram_re) begin
      rd_oor_q <= (32'(rd_idx) >= MAX_ORDER);
    end
    if (state_q == ST_C0) begin
      c0r_q <= cq_re;
      c0i_q <= cq_im;
    end
    if (state_q == ST_MR) begin
      prod_re_q <= mul_p[PPROD_W-1:0];
    end
    if (state_q == ST_MI) begin
      acc_q <= ACC_W'(prod_re_q) + ACC_W'($signed(mul_p[PPROD_W-1:0]));
    end
    if (out_load) begin
      llr_q  <= llr_d;
      sym_q  <= q_q;
      last_q <= at_top;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign llr_value_o    = llr_q;
  assign symbol_value_o = sym_q;
  assign last_o         = last_q;

endmodule

@@ rtl/core/nlldd_checker.sv @@
// Port-level checker for the nonbinary LLR demapper unit, with its bind.
// No package dependency; attaches to nonbinary_llr_demapper_depuncture_unit.
module nlldd_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input logic [31:0] llr_value_o,
  input logic [5:0]  symbol_value_o,
  input logic        last_o
);

  logic [5:0] expect_q;

  // next symbol expected in the run: 1 after a last word, else previous + 1
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expect_q <= 6'd1;
    end else if (out_valid_o && out_ready_i) begin
      expect_q <= last_o ? 6'd1 : symbol_value_o + 6'd1;
    end
  end

  // stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(llr_value_o)
      && $stable(symbol_value_o) && $stable(last_o))
    else $error("output word changed while stalled");

  // runs count up from 1 without gaps
  a_sym_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> symbol_value_o == expect_q)
    else $error("symbol value out of order");

  // a run in progress keeps the input side closed
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> !in_ready_o)
    else $error("input open in the middle of a run");

  // symbol zero is never reported
  a_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> symbol_value_o != 6'd0)
    else $error("zero symbol value");

endmodule

bind nonbinary_llr_demapper_depuncture_unit nlldd_checker u_nlldd_checker (.*);
